// ===== design/crfm_pkg.sv =====
// Package for the clock replacement frame manager: sizes, codes and the frame entry type.
// Used by every file of the design folder; it depends on nothing else.
package crfm_pkg;
  localparam int NUM_FRAMES = 16;
  localparam int FW = $clog2(NUM_FRAMES);
  localparam int CW = FW + 1;

  localparam logic [2:0] OP_READ    = 3'd0;
  localparam logic [2:0] OP_UNPIN   = 3'd1;
  localparam logic [2:0] OP_ALLOC   = 3'd2;
  localparam logic [2:0] OP_DISPOSE = 3'd3;
  localparam logic [2:0] OP_FLUSH   = 3'd4;

  localparam logic [2:0] ST_HIT       = 3'd0;
  localparam logic [2:0] ST_ALLOCATED = 3'd1;
  localparam logic [2:0] ST_EXCEEDED  = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_NOT_PINNED = 3'd4;
  localparam logic [2:0] ST_DONE      = 3'd5;

  localparam logic [0:0] REG_FRAMES = 1'd0;

  typedef struct packed {
    logic        valid;
    logic        refb;
    logic        dirty;
    logic [7:0]  pins;
    logic [7:0]  file;
    logic [31:0] page;
  } entry_t;

  typedef struct packed {
    logic [2:0]    status;
    logic [FW-1:0] frame;
    logic          vv;
    logic          wb;
    logic [7:0]    vf;
    logic [31:0]   vp;
    logic          last;
  } result_t;
endpackage

// ===== design/crfm_table.sv =====
// Frame table memory: one synchronous write port and one registered read port.
// Depends on crfm_pkg for the entry type and the frame count.
module crfm_table (
  input  logic                     clk,
  input  logic                     we,
  input  logic [crfm_pkg::FW-1:0]  waddr,
  input  crfm_pkg::entry_t         wdata,
  input  logic [crfm_pkg::FW-1:0]  raddr,
  output crfm_pkg::entry_t         rdata
);
  crfm_pkg::entry_t mem [crfm_pkg::NUM_FRAMES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== design/clock_replacement_frame_manager.sv =====
// Top level of the clock replacement frame manager: APB register, sequencer and result register.
// Depends on crfm_pkg and crfm_table. One item at a time; the single table read port sets the pace.
// A hit, unpin, dispose or flush searches the frames (a search and a wait state per frame),
// then passes through the action state and waits on output stalls; a miss or allocate adds
// a clock sweep in which each frame is visited at most twice, each visit through S_CLK and S_CLKW.
// Reset clears control state, then a clearing pass zeroes every frame entry with no beat accepted.
module clock_replacement_frame_manager (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // operation[2:0], file_id[10:3], page_no[42:11], dirty[43]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // status[2:0], frame[6:3], victim_valid[7], writeback[8],
                                  // victim_file[16:9], victim_page[48:17]
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  localparam int FW = crfm_pkg::FW;
  localparam int CW = crfm_pkg::CW;
  localparam logic REG_IDX = crfm_pkg::REG_FRAMES;

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b00000001,
    S_IDLE   = 8'b00000010,
    S_SRCH   = 8'b00000100,
    S_SRCHW  = 8'b00001000,
    S_ACT    = 8'b00010000,
    S_CLK    = 8'b00100000,
    S_CLKW   = 8'b01000000,
    S_OUT    = 8'b10000000
  } state_t;

  state_t state_r, state_nxt;
  logic [4:0] fiu_r;
  logic [FW-1:0] hand_r, hand_nxt;
  logic [FW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] pinned_r, pinned_nxt;
  logic [crfm_pkg::NUM_FRAMES-1:0] seen_r, seen_nxt;
  logic [2:0]  op_r;
  logic [7:0]  file_r;
  logic [31:0] page_r;
  logic        dirty_r;
  logic        hit_r, hit_nxt;
  logic [FW-1:0] hidx_r, hidx_nxt;
  logic        pend_r, pend_nxt;   // a flush result waits in pres_r
  crfm_pkg::result_t res_r, res_nxt, pres_r, pres_nxt;
  logic        ovalid_r, ovalid_nxt;

  logic we;
  logic [FW-1:0] waddr, raddr;
  crfm_pkg::entry_t wdata, rd;

  crfm_table u_table (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rd)
  );

  // Effective frame count: at least one, at most NUM_FRAMES.
  logic [CW-1:0] n_eff;
  always_comb begin
    if (fiu_r == 5'd0) n_eff = CW'(1);
    else if (32'(fiu_r) > 32'(crfm_pkg::NUM_FRAMES)) n_eff = CW'(crfm_pkg::NUM_FRAMES);
    else n_eff = CW'(fiu_r);
  end

  function automatic logic [FW-1:0] adv(input logic [FW-1:0] h, input logic [CW-1:0] n);
    if ((CW'(h) + CW'(1)) >= n) return '0;
    return h + FW'(1);
  endfunction

  logic cfg_wr;
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[2] == REG_IDX) ? {27'd0, fiu_r} : 32'd0;

  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = ovalid_r;
  assign out_tdata = {7'd0, res_r.vp, res_r.vf, res_r.wb, res_r.vv, res_r.frame, res_r.status};
  assign out_tlast = res_r.last;

  logic out_free;
  assign out_free = !ovalid_r || out_tready;

  function automatic crfm_pkg::result_t mk(input logic [2:0] st, input logic [FW-1:0] fr);
    crfm_pkg::result_t r;
    r = '0;
    r.status = st;
    r.frame = fr;
    r.last = 1'b1;
    return r;
  endfunction

  logic key_match;
  assign key_match = rd.valid && rd.file == file_r && rd.page == page_r;

  logic file_match;
  assign file_match = rd.valid && rd.file == file_r;

  always_comb begin
    state_nxt = state_r;
    hand_nxt = hand_r;
    idx_nxt = idx_r;
    pinned_nxt = pinned_r;
    seen_nxt = seen_r;
    hit_nxt = hit_r;
    hidx_nxt = hidx_r;
    pend_nxt = pend_r;
    pres_nxt = pres_r;
    res_nxt = res_r;
    ovalid_nxt = ovalid_r && !out_tready;
    we = 1'b0;
    waddr = idx_r;
    wdata = rd;
    raddr = idx_r;
    case (state_r)
      S_CLEAR: begin
        we = 1'b1;
        wdata = '0;
        idx_nxt = idx_r + FW'(1);
        if (idx_r == FW'(crfm_pkg::NUM_FRAMES - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        idx_nxt = '0;
        hit_nxt = 1'b0;
        pend_nxt = 1'b0;
        if (in_tvalid) state_nxt = S_SRCH;
      end
      S_SRCH: state_nxt = S_SRCHW;   // read address idx_r issued
      S_SRCHW: begin
        // rd holds entry idx_r
        if (op_r == crfm_pkg::OP_FLUSH) begin
          // A matching frame is held back one beat so that the final one can carry last.
          if (file_match && pend_r && !out_free) begin
            state_nxt = S_SRCHW;
          end else begin
            if (file_match) begin
              if (pend_r) begin
                res_nxt = pres_r;
                ovalid_nxt = 1'b1;
              end
              we = 1'b1;
              wdata = '0;
              wdata.file = rd.file;
              wdata.page = rd.page;
              pres_nxt = mk(crfm_pkg::ST_DONE, idx_r);
              pres_nxt.vv = 1'b1;
              pres_nxt.wb = rd.dirty;
              pres_nxt.vf = rd.file;
              pres_nxt.vp = rd.page;
              pres_nxt.last = 1'b0;
              pend_nxt = 1'b1;
            end
            if (CW'(idx_r) + CW'(1) >= n_eff) state_nxt = S_ACT;
            else begin
              idx_nxt = idx_r + FW'(1);
              state_nxt = S_SRCH;
            end
          end
        end else if (!hit_r && key_match) begin
          hit_nxt = 1'b1;
          hidx_nxt = idx_r;
          state_nxt = S_ACT;
          idx_nxt = idx_r;
        end else if (CW'(idx_r) + CW'(1) >= n_eff) begin
          state_nxt = S_ACT;
        end else begin
          idx_nxt = idx_r + FW'(1);
          state_nxt = S_SRCH;
        end
      end
      S_ACT: begin
        // for a hit, rd still holds the hit entry (address unchanged)
        raddr = hidx_r;
        if (out_free) begin
          case (op_r)
            crfm_pkg::OP_READ: begin
              if (hit_r) begin
                we = 1'b1;
                waddr = hidx_r;
                wdata.refb = 1'b1;
                if (rd.pins != 8'hFF) wdata.pins = rd.pins + 8'd1;
                res_nxt = mk(crfm_pkg::ST_HIT, hidx_r);
                ovalid_nxt = 1'b1;
                state_nxt = S_IDLE;
              end else begin
                hand_nxt = adv(hand_r, n_eff);
                pinned_nxt = '0;
                seen_nxt = '0;
                state_nxt = S_CLK;
              end
            end
            crfm_pkg::OP_ALLOC: begin
              if (hit_r) begin
                we = 1'b1;
                waddr = hidx_r;
                wdata.valid = 1'b0;
                wdata.refb = 1'b0;
                wdata.dirty = 1'b0;
                wdata.pins = 8'd0;
              end
              hand_nxt = adv(hand_r, n_eff);
              pinned_nxt = '0;
              seen_nxt = '0;
              state_nxt = S_CLK;
            end
            crfm_pkg::OP_UNPIN: begin
              if (!hit_r) res_nxt = mk(crfm_pkg::ST_NOT_FOUND, '0);
              else if (rd.pins == 8'd0) res_nxt = mk(crfm_pkg::ST_NOT_PINNED, hidx_r);
              else begin
                we = 1'b1;
                waddr = hidx_r;
                wdata.pins = rd.pins - 8'd1;
                if (dirty_r) wdata.dirty = 1'b1;
                res_nxt = mk(crfm_pkg::ST_HIT, hidx_r);
              end
              ovalid_nxt = 1'b1;
              state_nxt = S_IDLE;
            end
            crfm_pkg::OP_DISPOSE: begin
              if (!hit_r) res_nxt = mk(crfm_pkg::ST_NOT_FOUND, '0);
              else begin
                we = 1'b1;
                waddr = hidx_r;
                wdata.valid = 1'b0;
                wdata.refb = 1'b0;
                wdata.dirty = 1'b0;
                wdata.pins = 8'd0;
                res_nxt = mk(crfm_pkg::ST_DONE, hidx_r);
              end
              ovalid_nxt = 1'b1;
              state_nxt = S_IDLE;
            end
            crfm_pkg::OP_FLUSH: begin
              // the held beat becomes the last one; otherwise a lone done beat
              if (pend_r) begin
                res_nxt = pres_r;
                res_nxt.last = 1'b1;
              end else res_nxt = mk(crfm_pkg::ST_DONE, '0);
              ovalid_nxt = 1'b1;
              pend_nxt = 1'b0;
              state_nxt = S_IDLE;
            end
            default: begin
              res_nxt = mk(crfm_pkg::ST_NOT_FOUND, '0);
              ovalid_nxt = 1'b1;
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_CLK: begin
        // hand wraps if beyond a shrunk count
        if (CW'(hand_r) >= n_eff) hand_nxt = '0;
        raddr = (CW'(hand_r) >= n_eff) ? '0 : hand_r;
        state_nxt = S_CLKW;
      end
      S_CLKW: begin
        raddr = hand_r;
        waddr = hand_r;
        if (rd.valid && rd.refb) begin
          we = 1'b1;
          wdata.refb = 1'b0;
          hand_nxt = adv(hand_r, n_eff);
          state_nxt = S_CLK;
        end else if (rd.valid && rd.pins != 8'd0) begin
          if (!seen_r[hand_r]) begin
            seen_nxt[hand_r] = 1'b1;
            pinned_nxt = pinned_r + CW'(1);
          end
          hand_nxt = adv(hand_r, n_eff);
          if (!seen_r[hand_r] && pinned_r + CW'(1) >= n_eff) begin
            pres_nxt = mk(crfm_pkg::ST_EXCEEDED, '0);
            state_nxt = S_OUT;
          end else state_nxt = S_CLK;
        end else begin
          we = 1'b1;
          wdata.valid = 1'b1;
          wdata.refb = 1'b1;
          wdata.dirty = 1'b0;
          wdata.pins = 8'd1;
          wdata.file = file_r;
          wdata.page = page_r;
          pres_nxt = mk(crfm_pkg::ST_ALLOCATED, hand_r);
          pres_nxt.vv = rd.valid;
          pres_nxt.wb = rd.valid && rd.dirty;
          pres_nxt.vf = rd.valid ? rd.file : 8'd0;
          pres_nxt.vp = rd.valid ? rd.page : 32'd0;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        raddr = hand_r;
        if (out_free) begin
          res_nxt = pres_r;
          ovalid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      fiu_r <= 5'd16;
      hand_r <= FW'(crfm_pkg::NUM_FRAMES - 1);
      idx_r <= '0;
      ovalid_r <= 1'b0;
      pend_r <= 1'b0;
      hit_r <= 1'b0;
      pinned_r <= '0;
      seen_r <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r <= idx_nxt;
      pend_r <= pend_nxt;
      hit_r <= hit_nxt;
      pinned_r <= pinned_nxt;
      seen_r <= seen_nxt;
      hand_r <= hand_nxt;
      ovalid_r <= ovalid_nxt;
      if (cfg_wr && cfg_paddr[2] == REG_IDX) begin
        fiu_r <= cfg_pwdata[4:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    pres_r <= pres_nxt;
    res_r <= res_nxt;
    hidx_r <= hidx_nxt;
    if (in_tvalid && in_tready) begin
      op_r <= in_tdata[2:0];
      file_r <= in_tdata[10:3];
      page_r <= in_tdata[42:11];
      dirty_r <= in_tdata[43];
    end
  end

  logic unused_bits;
  assign unused_bits = (|in_tdata[47:44]) ^ (|cfg_paddr[1:0]) ^ (|cfg_pwdata[31:5]);
endmodule

// ===== design/crfm_checker.sv =====
// Port-level checker for the clock replacement frame manager, bound to the top level.
// Depends on crfm_pkg for the status codes.
module crfm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata,
  input logic        out_tlast,
  input logic        cfg_pready
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[2:0] <= crfm_pkg::ST_DONE)
    else $error("status code out of range");

  a_flush_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[2:0] == crfm_pkg::ST_DONE && out_tdata[7])
    else $error("only flush beats may be non-final");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item accepted while busy");

  a_pready: assert property (@(posedge clk) cfg_pready)
    else $error("pready dropped");
endmodule

bind clock_replacement_frame_manager crfm_checker u_crfm_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tlast(out_tlast), .cfg_pready(cfg_pready)
);

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the clock replacement frame manager: random and directed beats,
// a scoreboard class holding a frame-table predictor, APB register writes between phases.
// Depends on crfm_pkg and the design top level only.
module testbench;

  // Holds a copy of the frame table and the expected result beats in order.
  class frame_scoreboard;
    bit        valid[16], refb[16], dirty[16];
    bit [7:0]  pins[16], file[16];
    bit [31:0] page[16];
    int        hand;
    bit [4:0]  frames_reg;
    crfm_pkg::result_t pending[$];
    int        errors, inputs_seen, results_seen;

    function new();
      frames_reg = 16;
      foreach (valid[i]) begin
        valid[i] = 0; refb[i] = 0; dirty[i] = 0; pins[i] = 0; file[i] = 0; page[i] = 0;
      end
      hand = 15;
    endfunction

    function int active_frames();
      int n;
      n = frames_reg;
      if (n < 1) n = 1;
      if (n > 16) n = 16;
      return n;
    endfunction

    function void step_hand(int n);
      hand = (hand + 1 >= n) ? 0 : hand + 1;
    endfunction

    function void push(bit [2:0] st, int fr, bit vv, bit wb, bit [7:0] vf, bit [31:0] vp,
                       bit lst);
      crfm_pkg::result_t r;
      r.status = st; r.frame = 4'(fr); r.vv = vv; r.wb = wb; r.vf = vf; r.vp = vp;
      r.last = lst;
      pending.push_back(r);
    endfunction

    function void drop_frame(int i);
      valid[i] = 0; refb[i] = 0; dirty[i] = 0; pins[i] = 0;
    endfunction

    // Clock sweep followed by installation of the new key, or an exceeded result if all are pinned.
    function void install(int n, bit [7:0] f, bit [31:0] p);
      bit seen[16];
      int pinned, h, pick;
      pinned = 0;
      pick = -1;
      foreach (seen[i]) seen[i] = 0;
      step_hand(n);
      while (pinned < n && pick < 0) begin
        h = hand;
        if (h >= n) begin
          hand = 0; h = 0;
        end
        if (valid[h] && refb[h]) begin
          refb[h] = 0; step_hand(n);
        end else if (valid[h] && pins[h] > 0) begin
          if (!seen[h]) begin
            seen[h] = 1; pinned++;
          end
          step_hand(n);
        end else begin
          pick = h;
        end
      end
      if (pick < 0) begin
        push(crfm_pkg::ST_EXCEEDED, 0, 0, 0, 0, 0, 1);
        return;
      end
      if (valid[pick]) begin
        push(crfm_pkg::ST_ALLOCATED, pick, 1, dirty[pick], file[pick], page[pick], 1);
      end else push(crfm_pkg::ST_ALLOCATED, pick, 0, 0, 0, 0, 1);
      valid[pick] = 1; refb[pick] = 1; dirty[pick] = 0; pins[pick] = 1;
      file[pick] = f; page[pick] = p;
    endfunction

    function void note_input(bit [2:0] op, bit [7:0] f, bit [31:0] p, bit d);
      int n, hit, cnt;
      n = active_frames();
      hit = -1;
      cnt = 0;
      inputs_seen++;
      for (int i = n - 1; i >= 0; i--)
        if (valid[i] && file[i] == f && page[i] == p) hit = i;
      case (op)
        crfm_pkg::OP_READ: begin
          if (hit < 0) install(n, f, p);
          else begin
            refb[hit] = 1;
            if (pins[hit] != 8'hff) pins[hit]++;
            push(crfm_pkg::ST_HIT, hit, 0, 0, 0, 0, 1);
          end
        end
        crfm_pkg::OP_UNPIN: begin
          if (hit < 0) push(crfm_pkg::ST_NOT_FOUND, 0, 0, 0, 0, 0, 1);
          else if (pins[hit] == 0) push(crfm_pkg::ST_NOT_PINNED, hit, 0, 0, 0, 0, 1);
          else begin
            pins[hit]--;
            if (d) dirty[hit] = 1;
            push(crfm_pkg::ST_HIT, hit, 0, 0, 0, 0, 1);
          end
        end
        crfm_pkg::OP_ALLOC: begin
          if (hit >= 0) drop_frame(hit);
          install(n, f, p);
        end
        crfm_pkg::OP_DISPOSE: begin
          if (hit < 0) push(crfm_pkg::ST_NOT_FOUND, 0, 0, 0, 0, 0, 1);
          else begin
            drop_frame(hit);
            push(crfm_pkg::ST_DONE, hit, 0, 0, 0, 0, 1);
          end
        end
        crfm_pkg::OP_FLUSH: begin
          for (int i = 0; i < n; i++)
            if (valid[i] && file[i] == f) begin
              push(crfm_pkg::ST_DONE, i, 1, dirty[i], file[i], page[i], 0);
              drop_frame(i);
              cnt++;
            end
          if (cnt == 0) push(crfm_pkg::ST_DONE, 0, 0, 0, 0, 0, 1);
          else pending[$].last = 1;
        end
        default: push(crfm_pkg::ST_NOT_FOUND, 0, 0, 0, 0, 0, 1);
      endcase
    endfunction

    function void check_result(logic [55:0] data, logic lst);
      crfm_pkg::result_t e;
      results_seen++;
      if (pending.size() == 0) begin
        $error("result beat with nothing expected: tdata %h", data);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (data[2:0] !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, data[2:0]); errors++;
      end
      if (data[6:3] !== e.frame) begin
        $error("frame: expected %0d, got %0d", e.frame, data[6:3]); errors++;
      end
      if (data[7] !== e.vv) begin
        $error("victim_valid: expected %0d, got %0d", e.vv, data[7]); errors++;
      end
      if (data[8] !== e.wb) begin
        $error("writeback: expected %0d, got %0d", e.wb, data[8]); errors++;
      end
      if (data[16:9] !== e.vf) begin
        $error("victim_file: expected %0d, got %0d", e.vf, data[16:9]); errors++;
      end
      if (data[48:17] !== e.vp) begin
        $error("victim_page: expected %h, got %h", e.vp, data[48:17]); errors++;
      end
      if (lst !== e.last) begin
        $error("last: expected %0d, got %0d", e.last, lst); errors++;
      end
    endfunction
  endclass

  logic        clk, rst_n;
  logic        in_tvalid, in_tready, out_tvalid, out_tready, out_tlast;
  logic [47:0] in_tdata;   // operation[2:0], file_id[10:3], page_no[42:11], dirty[43]
  logic [55:0] out_tdata;  // status[2:0], frame[6:3], victim_valid[7], writeback[8],
                           // victim_file[16:9], victim_page[48:17]
  logic        cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;

  frame_scoreboard sb;
  bit send_busy, hold_req;

  clock_replacement_frame_manager dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("FAILED: results differ");
    $finish;
  end

  task automatic send_beat(bit [2:0] op, bit [7:0] f, bit [31:0] p, bit d);
    int gap;
    gap = send_busy ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, d, p, f, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(op, f, p, d);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_frames(bit [4:0] v);
    @(posedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_paddr <= {crfm_pkg::REG_FRAMES, 2'b00};
    cfg_pwdata <= 32'(v); cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    sb.frames_reg = v;
  endtask

  task automatic random_beats(int count);
    int r;
    bit [7:0] f;
    bit [31:0] p;
    for (int k = 0; k < count; k++) begin
      if (k % 30 == 0) send_busy = $urandom_range(0, 2) == 0;
      r = $urandom_range(0, 99);
      f = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 2) * 127);
      p = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 5);
      if (r < 35) send_beat(crfm_pkg::OP_READ, f, p, 0);
      else if (r < 60) send_beat(crfm_pkg::OP_UNPIN, f, p, 1'($urandom_range(0, 1)));
      else if (r < 75) send_beat(crfm_pkg::OP_ALLOC, f, p, 1'($urandom_range(0, 1)));
      else if (r < 85) send_beat(crfm_pkg::OP_DISPOSE, f, p, 1'($urandom_range(0, 1)));
      else if (r < 95) send_beat(crfm_pkg::OP_FLUSH, f, p, 1'($urandom_range(0, 1)));
      else send_beat(3'($urandom_range(5, 7)), f, p, 1'($urandom_range(0, 1)));
    end
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    int gap;
    bit quiet;
    bit held;
    held = 0;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      if ($urandom_range(0, 40) == 0) quiet = 1'($urandom_range(0, 1));
      if (hold_req && !held) begin
        out_tready <= 1'b0;
        repeat (600) @(posedge clk);
        held = 1;
      end
      gap = quiet ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      sb.check_result(out_tdata, out_tlast);
    end
  end

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0; in_tdata = '0;
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0; cfg_paddr = '0; cfg_pwdata = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    write_frames(16);

    // Directed beats: miss, hit, unpin paths, extremes of the key, every operation, two undefined codes.
    send_beat(crfm_pkg::OP_READ, 8'd0, 32'd0, 0);
    send_beat(crfm_pkg::OP_READ, 8'd0, 32'd0, 0);
    send_beat(crfm_pkg::OP_UNPIN, 8'd0, 32'd0, 1);
    send_beat(crfm_pkg::OP_UNPIN, 8'd0, 32'd0, 0);
    send_beat(crfm_pkg::OP_UNPIN, 8'd0, 32'd0, 0);
    send_beat(crfm_pkg::OP_UNPIN, 8'd9, 32'd9, 1);
    send_beat(crfm_pkg::OP_ALLOC, 8'hff, 32'hffff_ffff, 0);
    send_beat(crfm_pkg::OP_ALLOC, 8'hff, 32'hffff_ffff, 1);
    send_beat(crfm_pkg::OP_READ, 8'hff, 32'h8000_0000, 0);
    send_beat(crfm_pkg::OP_DISPOSE, 8'hff, 32'h8000_0000, 0);
    send_beat(crfm_pkg::OP_DISPOSE, 8'hff, 32'h8000_0000, 0);
    send_beat(crfm_pkg::OP_FLUSH, 8'hff, 32'd0, 0);
    send_beat(crfm_pkg::OP_FLUSH, 8'd0, 32'd0, 0);
    send_beat(crfm_pkg::OP_FLUSH, 8'd0, 32'd0, 0);
    send_beat(3'd5, 8'd1, 32'd1, 1);
    send_beat(3'd7, 8'd1, 32'd1, 0);
    drain();

    // A single frame: most misses find it pinned.
    write_frames(1);
    random_beats(30);
    drain();

    // Repeated pins and unpins of one key, then a flush of its file.
    write_frames(2);
    send_busy = 1;
    repeat (6) send_beat(crfm_pkg::OP_READ, 8'd3, 32'd3, 0);
    repeat (3) send_beat(crfm_pkg::OP_UNPIN, 8'd3, 32'd3, 1);
    send_beat(crfm_pkg::OP_FLUSH, 8'd3, 32'd0, 0);
    drain();

    write_frames(5);
    random_beats(50);
    drain();

    write_frames(16);
    hold_req = 1;
    random_beats(70);
    drain();

    write_frames(3);
    random_beats(25);
    drain();

    $display("Covered %0d input beats and %0d result beats over frame counts 16, 1, 2, 5, 16, 3.",
             sb.inputs_seen, sb.results_seen);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
